### hw/rtl/cfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types, constants and lookup functions of the CAN stream deframer.
// ----------------------------------------------------------------------------
package cfd_pkg;

   localparam int DEFAULT_MAX_READ_BYTES = 65536;
   localparam int MAX_DATA_BYTES         = 8;
   localparam int HDR_BYTES              = 11;
   localparam int SYNC_BYTES             = 6;
   localparam int MSGID_POS              = 6;
   localparam int LEN_POS                = 9;
   localparam int NOTE_BYTES             = 5;

   localparam logic [15:0] ACCEPTED_ID_RESET = 16'd1;

   localparam logic [7:0] CTRL_NOTE_MASK = 8'h80;
   localparam logic [7:0] CTRL_TS_MASK   = 8'h60;
   localparam logic [7:0] CTRL_EXT_MASK  = 8'h10;
   localparam logic [7:0] CTRL_LEN_MASK  = 8'h0F;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic KIND_FRAME  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [1:0] STATUS_DELIVERED  = 2'd0;
   localparam logic [1:0] STATUS_SHORT_READ = 2'd1;
   localparam logic [1:0] STATUS_BAD_HEADER = 2'd2;
   localparam logic [1:0] STATUS_NO_FRAMES  = 2'd3;

   typedef struct packed {
      logic        kind;
      logic [31:0] id;
      logic        ext;
      logic [3:0]  len;
      logic [63:0] data;
      logic [1:0]  status;
      logic        last;
   } result_type;

   // up to two results produced by one byte transfer
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   typedef struct packed {
      logic                   room_for_two;
      logic [QUEUE_CNT_W-1:0] count;
   } queue_status_type;

   function automatic logic [7:0] sync_byte(input logic [2:0] idx);
      logic [7:0] b;
      unique case (idx)
         3'd0:    b = 8'h41;
         3'd1:    b = 8'h58;
         3'd2:    b = 8'h49;
         3'd3:    b = 8'h4F;
         3'd4:    b = 8'hBA;
         3'd5:    b = 8'h36;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [2:0] ts_len(input logic [1:0] code);
      logic [2:0] n;
      unique case (code)
         2'd0: n = 3'd0;
         2'd1: n = 3'd1;
         2'd2: n = 3'd2;
         2'd3: n = 3'd4;
      endcase
      return n;
   endfunction

endpackage

### hw/rtl/cfd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_parser
// Per-byte header and body walker; holds the read state and emits results.
// ----------------------------------------------------------------------------
module cfd_parser #(
   parameter int MAX_READ_BYTES = cfd_pkg::DEFAULT_MAX_READ_BYTES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [7:0]        rx_byte,
   input  logic              end_of_read,
   input  logic [15:0]       accepted_id,
   output cfd_pkg::push_type push
);
   import cfd_pkg::*;

   localparam int OFFSET_W = $clog2(MAX_READ_BYTES + 1);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_SKIP,
      PH_CTRL,
      PH_NOTE,
      PH_FRAME
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [OFFSET_W-1:0]   offset_ff, offset_in;
   logic [3:0]            index_ff, index_in;
   logic [15:0]           msgid_ff, msgid_in;
   logic [15:0]           body_ff, body_in;
   logic [7:0]            ctrl_ff, ctrl_in;
   logic [4:0]            fidx_ff, fidx_in;
   logic [31:0]           id_ff, id_in;
   logic [63:0]           data_ff, data_in;
   logic                  frames_ff, frames_in;
   logic                  seen_ff, seen_in;
   logic                  stopped_ff, stopped_in;

   logic       done;
   logic [2:0] ts, ids, c_ts, c_ids;
   logic [4:0] total, after, p_next, rel, drel;
   logic [1:0] status;
   result_type frame_r, status_r;

   always_comb begin
      phase_in   = phase_ff;
      offset_in  = offset_ff;
      index_in   = index_ff;
      msgid_in   = msgid_ff;
      body_in    = body_ff;
      ctrl_in    = ctrl_ff;
      fidx_in    = fidx_ff;
      id_in      = id_ff;
      data_in    = data_ff;
      frames_in  = frames_ff;
      seen_in    = seen_ff;
      stopped_in = stopped_ff;
      done       = 1'b0;
      status     = STATUS_NO_FRAMES;
      push       = '0;

      // control byte fields, both for a new control byte and the held one
      ts    = ts_len(rx_byte[6:5]);
      ids   = (rx_byte & CTRL_EXT_MASK) != 8'h00 ? 3'd4 : 3'd2;
      total = 5'd1 + {2'b0, ts} + {2'b0, ids} + {1'b0, rx_byte[3:0]};
      c_ts  = ts_len(ctrl_ff[6:5]);
      c_ids = (ctrl_ff & CTRL_EXT_MASK) != 8'h00 ? 3'd4 : 3'd2;
      after = {2'b0, c_ts} + {2'b0, c_ids} + {1'b0, ctrl_ff[3:0]};
      rel   = fidx_ff - {2'b0, c_ts};
      drel  = rel - {2'b0, c_ids};
      p_next = fidx_ff + 5'd1;

      if (take) begin
         if (offset_ff < OFFSET_W'(MAX_READ_BYTES)) begin
            offset_in = offset_ff + OFFSET_W'(1);
            if (!stopped_ff) begin
               if (phase_ff == PH_HEADER) begin
                  if (index_ff < 4'(SYNC_BYTES) && rx_byte != sync_byte(index_ff[2:0])) begin
                     stopped_in = 1'b1;
                  end else begin
                     if (index_ff == 4'(MSGID_POS))     msgid_in[7:0]  = rx_byte;
                     if (index_ff == 4'(MSGID_POS + 1)) msgid_in[15:8] = rx_byte;
                     if (index_ff == 4'(LEN_POS))       body_in[7:0]   = rx_byte;
                     if (index_ff == 4'(LEN_POS + 1))   body_in[15:8]  = rx_byte;
                     if (index_ff == 4'(HDR_BYTES - 1)) begin
                        index_in = 4'd0;
                        seen_in  = 1'b1;
                        if (body_in == 16'd0) begin
                           phase_in = PH_HEADER;
                        end else if (msgid_in == accepted_id) begin
                           phase_in = PH_CTRL;
                        end else begin
                           phase_in = PH_SKIP;
                        end
                     end else begin
                        index_in = index_ff + 4'd1;
                     end
                  end
               end else begin
                  unique case (phase_ff)
                     PH_CTRL: begin
                        if ((rx_byte & CTRL_NOTE_MASK) != 8'h00) begin
                           phase_in = PH_NOTE;
                           fidx_in  = 5'(NOTE_BYTES - 1);
                        end else if ({11'b0, total} > body_ff) begin
                           phase_in = PH_SKIP;
                        end else begin
                           phase_in = PH_FRAME;
                           ctrl_in  = rx_byte;
                           fidx_in  = 5'd0;
                           id_in    = '0;
                           data_in  = '0;
                        end
                     end
                     PH_NOTE: begin
                        fidx_in = fidx_ff - 5'd1;
                        if (fidx_in == 5'd0) phase_in = PH_CTRL;
                     end
                     PH_FRAME: begin
                        if (fidx_ff >= {2'b0, c_ts} && rel < {2'b0, c_ids}) begin
                           id_in[8*rel[1:0] +: 8] = rx_byte;
                        end else if (fidx_ff >= {2'b0, c_ts} && drel < 5'(MAX_DATA_BYTES)) begin
                           data_in[8*drel[2:0] +: 8] = rx_byte;
                        end
                        fidx_in = p_next;
                        if (p_next >= after) begin
                           done      = 1'b1;
                           frames_in = 1'b1;
                           phase_in  = PH_CTRL;
                        end
                     end
                     default: begin
                        // skip phase: only the body count moves
                     end
                  endcase
                  body_in = body_ff - 16'd1;
                  if (body_in == 16'd0) phase_in = PH_HEADER;
               end
            end
         end

         if (offset_in < OFFSET_W'(HDR_BYTES)) begin
            status = STATUS_SHORT_READ;
         end else if (frames_in) begin
            status = STATUS_DELIVERED;
         end else if (!seen_in) begin
            status = STATUS_BAD_HEADER;
         end else begin
            status = STATUS_NO_FRAMES;
         end
      end

      frame_r        = '0;
      frame_r.kind   = KIND_FRAME;
      frame_r.id     = id_in;
      frame_r.ext    = ctrl_ff[4];
      frame_r.len    = ctrl_ff[3:0];
      frame_r.data   = data_in;
      frame_r.status = STATUS_DELIVERED;
      frame_r.last   = !end_of_read;
      status_r        = '0;
      status_r.kind   = KIND_STATUS;
      status_r.status = status;
      status_r.last   = 1'b1;

      if (take) begin
         if (done && end_of_read) begin
            push.count  = 2'd2;
            push.first  = frame_r;
            push.second = status_r;
         end else if (done) begin
            push.count = 2'd1;
            push.first = frame_r;
         end else if (end_of_read) begin
            push.count = 2'd1;
            push.first = status_r;
         end
         if (end_of_read) begin
            phase_in   = PH_HEADER;
            offset_in  = '0;
            index_in   = 4'd0;
            frames_in  = 1'b0;
            seen_in    = 1'b0;
            stopped_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         offset_ff  <= '0;
         index_ff   <= 4'd0;
         frames_ff  <= 1'b0;
         seen_ff    <= 1'b0;
         stopped_ff <= 1'b0;
         msgid_ff   <= '0;
         body_ff    <= '0;
         ctrl_ff    <= '0;
         fidx_ff    <= '0;
         id_ff      <= '0;
         data_ff    <= '0;
      end else begin
         phase_ff   <= phase_in;
         offset_ff  <= offset_in;
         index_ff   <= index_in;
         frames_ff  <= frames_in;
         seen_ff    <= seen_in;
         stopped_ff <= stopped_in;
         msgid_ff   <= msgid_in;
         body_ff    <= body_in;
         ctrl_ff    <= ctrl_in;
         fidx_ff    <= fidx_in;
         id_ff      <= id_in;
         data_ff    <= data_in;
      end
   end

endmodule

### hw/rtl/cfd_result_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_result_queue
// Small result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module cfd_result_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  cfd_pkg::push_type         push,
   input  logic                      pop,
   output logic                      valid,
   output cfd_pkg::result_type       head,
   output cfd_pkg::queue_status_type status
);
   import cfd_pkg::*;

   result_type             slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ff, wr_in;
   logic [QUEUE_PTR_W-1:0] rd_ff, rd_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic [QUEUE_PTR_W-1:0] wr_next;

   assign valid   = count_ff != '0;
   assign head    = slot_ff[rd_ff];
   assign wr_next = wr_ff + QUEUE_PTR_W'(1);

   assign status.room_for_two = count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - 2);
   assign status.count        = count_ff;

   always_comb begin
      wr_in    = wr_ff + QUEUE_PTR_W'(push.count);
      rd_in    = pop ? rd_ff + QUEUE_PTR_W'(1) : rd_ff;
      count_in = count_ff + QUEUE_CNT_W'(push.count) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (push.count != 2'd0) slot_ff[wr_ff]   <= push.first;
      if (push.count == 2'd2) slot_ff[wr_next] <= push.second;
   end

endmodule

### hw/rtl/can_stream_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_stream_deframer
// Length-prefixed CAN stream deframer: scans each read for headers and
// emits decoded CAN frames and one status result per read.
// ----------------------------------------------------------------------------
// a result enters the result queue with its byte transfer; rsp offers the queue head
// throughput: one byte per cycle; the parser takes a byte whenever the
//   4-entry result queue has two free slots, results leave one per cycle when taken
// a byte ending both a frame and a read yields two results: frame, then status
// reset: synchronous; parser back to header phase, queue empty, message id 1
// ----------------------------------------------------------------------------
module can_stream_deframer #(
   parameter int MAX_READ_BYTES = cfd_pkg::DEFAULT_MAX_READ_BYTES
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,   // [7:0] rx_byte
   input  logic          req_tlast,   // end_of_read
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [103:0]  rsp_tdata,   // [31:0] frame_id, [32] frame_extended,
                                      // [36:33] frame_length, [100:37] payload,
                                      // [102:101] read_status, [103] zero
   output logic          rsp_tuser,   // [0] result_kind
   output logic          rsp_tlast,   // last_of_run
   input  logic          csr_wr_en,
   input  logic [15:0]   csr_wr_data
);
   import cfd_pkg::*;

   logic [15:0]      accepted_id_ff;
   logic             take;
   push_type         push;
   result_type       head;
   queue_status_type qstat;

   assign take = req_tvalid && req_tready;
   assign req_tready = qstat.room_for_two;

   always_ff @(posedge clock) begin
      if (reset) begin
         accepted_id_ff <= ACCEPTED_ID_RESET;
      end else if (csr_wr_en) begin
         accepted_id_ff <= csr_wr_data;
      end
   end

   cfd_parser #(
      .MAX_READ_BYTES(MAX_READ_BYTES)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .rx_byte     (req_tdata),
      .end_of_read (req_tlast),
      .accepted_id (accepted_id_ff),
      .push        (push)
   );

   cfd_result_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (rsp_tvalid && rsp_tready),
      .valid  (rsp_tvalid),
      .head   (head),
      .status (qstat)
   );

   assign rsp_tdata = {1'b0, head.status, head.data, head.len, head.ext, head.id};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

   // a double push only happens for a frame ending on the last byte of a read
   a_double_push: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> push.first.kind == KIND_FRAME && !push.first.last
                             && push.second.kind == KIND_STATUS && push.second.last)
      else $error("double push is not frame then status");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      qstat.count <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("result queue overflow");

   a_no_push_idle: assert property (@(posedge clock) disable iff (reset)
      !take |-> push.count == 2'd0)
      else $error("results pushed without a byte transfer");

   a_status_on_last: assert property (@(posedge clock) disable iff (reset)
      take && req_tlast |-> push.count != 2'd0)
      else $error("read end without status result");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("results offered right after reset");

endmodule

### bench/tb_can_stream_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_can_stream_deframer
// Self-checking bench for the CAN stream deframer. Reads built from headers,
// packed CAN frames, notifications and noise are streamed in byte by byte.
// A behavioral deframer in the bench predicts every frame and end-of-read
// status. Each result transfer is checked field by field in arrival order.
// Both stream sides idle at random, and the match id is changed between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_can_stream_deframer;

   localparam int READ_LIMIT    = 256;   // a small read limit keeps overlong reads cheap
   localparam int HDR_LEN       = 11;
   localparam int SYNC_LEN      = 6;
   localparam int MSGID_AT      = 6;
   localparam int LEN_AT        = 9;
   localparam int NOTE_LEN      = 5;
   localparam int DATA_KEEP     = 8;
   localparam int SETTLE_CYCLES = 16;
   localparam int LONG_HOLD     = 150;
   localparam int CYCLE_LIMIT   = 200000;

   localparam logic [47:0] SYNC_SEQ = 48'h36BA4F495841;   // byte 0 lowest
   localparam logic [11:0] TS_TABLE = {3'd4, 3'd2, 3'd1, 3'd0};

   typedef enum logic [2:0] {
      SCAN_HEADER, SCAN_SKIP, SCAN_CTRL, SCAN_NOTE, SCAN_FRAME
   } scan_phase_type;

   typedef struct {
      logic [7:0] data;
      logic       ends_read;
      bit         drain_first;
   } rx_item_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [7:0]    req_tdata = 8'h00;   // [7:0] rx_byte
   logic          req_tlast = 1'b0;    // end_of_read
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [103:0]  rsp_tdata;           // [31:0] id, [32] ext, [36:33] len,
                                       // [100:37] data, [102:101] status, [103] zero
   logic          rsp_tuser;           // [0] result_kind
   logic          rsp_tlast;           // last_of_run
   logic          csr_wr_en = 1'b0;
   logic [15:0]   csr_wr_data = 16'h0000;

   can_stream_deframer #(
      .MAX_READ_BYTES(READ_LIMIT)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   rx_item_type            rx_bytes[$];
   cfd_pkg::result_type    due_results[$];
   logic [7:0]             read_buf[$];
   logic [7:0]             body_buf[$];
   int                     errors = 0;
   bit                     calm = 1'b0;
   int unsigned            cycle_count = 0;

   // deframer state of the bench
   logic [15:0]    match_id = cfd_pkg::ACCEPTED_ID_RESET;
   int unsigned    rd_count = 0;
   scan_phase_type scan_phase = SCAN_HEADER;
   int unsigned    hdr_pos = 0;
   logic [15:0]    msg_id = '0;
   logic [15:0]    body_left = '0;
   logic [7:0]     ctrl = '0;
   int unsigned    fpos = 0;
   logic [31:0]    id_acc = '0;
   logic [63:0]    data_acc = '0;
   bit             got_frame = 1'b0;
   bit             got_header = 1'b0;
   bit             scan_halted = 1'b0;

   function automatic int unsigned stamp_len(input logic [1:0] code);
      return TS_TABLE[3*code +: 3];
   endfunction

   function automatic void add_read_byte(input logic [7:0] b);
      read_buf.insert(read_buf.size(), b);
   endfunction

   function automatic void add_body_byte(input logic [7:0] b);
      body_buf.insert(body_buf.size(), b);
   endfunction

   task automatic deframe_byte(input logic [7:0] b, input logic eor);
      cfd_pkg::result_type r;
      int unsigned ts, idn;
      bit done;
      done = 1'b0;
      if (rd_count < READ_LIMIT) begin
         rd_count++;
         if (!scan_halted) begin
            if (scan_phase == SCAN_HEADER) begin
               if (hdr_pos < SYNC_LEN && b != SYNC_SEQ[8*hdr_pos +: 8]) begin
                  scan_halted = 1'b1;
               end else begin
                  case (hdr_pos)
                     MSGID_AT:     msg_id = {8'h00, b};
                     MSGID_AT + 1: msg_id[15:8] = b;
                     LEN_AT:       body_left = {8'h00, b};
                     LEN_AT + 1:   body_left[15:8] = b;
                     default: ;
                  endcase
                  if (hdr_pos == HDR_LEN - 1) begin
                     hdr_pos = 0;
                     got_header = 1'b1;
                     if (body_left == 0)
                        scan_phase = SCAN_HEADER;
                     else if (msg_id == match_id)
                        scan_phase = SCAN_CTRL;
                     else
                        scan_phase = SCAN_SKIP;
                  end else begin
                     hdr_pos++;
                  end
               end
            end else begin
               case (scan_phase)
                  SCAN_CTRL: begin
                     ts = stamp_len(b[6:5]);
                     idn = b[4] ? 4 : 2;
                     if (b[7]) begin
                        scan_phase = SCAN_NOTE;
                        fpos = NOTE_LEN - 1;
                     end else if (1 + ts + idn + b[3:0] > body_left) begin
                        scan_phase = SCAN_SKIP;
                     end else begin
                        scan_phase = SCAN_FRAME;
                        ctrl = b;
                        fpos = 0;
                        id_acc = '0;
                        data_acc = '0;
                     end
                  end
                  SCAN_NOTE: begin
                     fpos--;
                     if (fpos == 0)
                        scan_phase = SCAN_CTRL;
                  end
                  SCAN_FRAME: begin
                     ts = stamp_len(ctrl[6:5]);
                     idn = ctrl[4] ? 4 : 2;
                     if (fpos >= ts && fpos < ts + idn)
                        id_acc |= {24'h0, b} << (8 * (fpos - ts));
                     else if (fpos >= ts + idn && fpos - ts - idn < DATA_KEEP)
                        data_acc |= {56'h0, b} << (8 * (fpos - ts - idn));
                     fpos++;
                     if (fpos >= ts + idn + ctrl[3:0]) begin
                        done = 1'b1;
                        scan_phase = SCAN_CTRL;
                     end
                  end
                  default: ;
               endcase
               body_left--;
               if (body_left == 0)
                  scan_phase = SCAN_HEADER;
            end
         end
      end

      if (done) begin
         r = '0;
         r.kind = cfd_pkg::KIND_FRAME;
         r.id = id_acc;
         r.ext = ctrl[4];
         r.len = ctrl[3:0];
         r.data = data_acc;
         r.status = cfd_pkg::STATUS_DELIVERED;
         r.last = !eor;
         due_results.insert(due_results.size(), r);
         got_frame = 1'b1;
      end
      if (eor) begin
         r = '0;
         r.kind = cfd_pkg::KIND_STATUS;
         r.last = 1'b1;
         if (rd_count < HDR_LEN)
            r.status = cfd_pkg::STATUS_SHORT_READ;
         else if (got_frame)
            r.status = cfd_pkg::STATUS_DELIVERED;
         else if (!got_header)
            r.status = cfd_pkg::STATUS_BAD_HEADER;
         else
            r.status = cfd_pkg::STATUS_NO_FRAMES;
         due_results.insert(due_results.size(), r);
         // everything but the match id starts over with the next read
         rd_count = 0;
         scan_phase = SCAN_HEADER;
         hdr_pos = 0;
         msg_id = '0;
         body_left = '0;
         ctrl = '0;
         fpos = 0;
         id_acc = '0;
         data_acc = '0;
         got_frame = 1'b0;
         got_header = 1'b0;
         scan_halted = 1'b0;
      end
   endtask

   // ---------------------------------------------------------------- stimulus

   task automatic put_header(input logic [15:0] mid, input logic [15:0] blen);
      int i;
      for (i = 0; i < SYNC_LEN; i++)
         add_read_byte(SYNC_SEQ[8*i +: 8]);
      add_read_byte(mid[7:0]);
      add_read_byte(mid[15:8]);
      add_read_byte(8'($urandom));   // version, not looked at
      add_read_byte(blen[7:0]);
      add_read_byte(blen[15:8]);
   endtask

   task automatic put_frames();
      int unsigned sel;
      logic [7:0] c;
      repeat ($urandom_range(1, 3)) begin
         sel = $urandom_range(0, 9);
         c = 8'($urandom);
         if (sel == 0) begin
            c[7] = 1'b1;
            add_body_byte(c);
            repeat (NOTE_LEN - 1) add_body_byte(8'($urandom));
         end else begin
            c[7] = 1'b0;
            if (sel > 2)
               c[3:0] = 4'($urandom_range(0, DATA_KEEP));
            add_body_byte(c);
            repeat (stamp_len(c[6:5]) + (c[4] ? 4 : 2) + c[3:0])
               add_body_byte(8'($urandom));
         end
      end
   endtask

   task automatic push_read(input bit drain);
      rx_item_type it;
      int i;
      for (i = 0; i < read_buf.size(); i++) begin
         it.data = read_buf[i];
         it.ends_read = (i == read_buf.size() - 1);
         it.drain_first = drain && i == 0;
         rx_bytes.insert(rx_bytes.size(), it);
      end
      read_buf.delete();
   endtask

   task automatic queue_read(input bit drain, input bit long_read, output int unsigned used);
      int unsigned pick, msgs, n, decl, k;
      int unsigned hdr_at[$];
      logic [15:0] mid;
      bit overlong;
      pick = $urandom_range(0, 29);
      overlong = long_read || pick == 4;
      if (pick < 2 && !overlong) begin
         repeat ($urandom_range(1, HDR_LEN - 1)) add_read_byte(8'($urandom));
      end else if (pick < 4 && !overlong) begin
         repeat ($urandom_range(HDR_LEN, 40)) add_read_byte(8'($urandom));
      end else begin
         n = $urandom_range(1, 3);
         msgs = 0;
         while (overlong ? read_buf.size() <= READ_LIMIT + 8 : msgs < n) begin
            body_buf.delete();
            put_frames();
            case ($urandom_range(0, 9))
               0:       mid = 16'($urandom);
               1:       mid = match_id ^ (16'h1 << $urandom_range(0, 15));
               default: mid = match_id;
            endcase
            case ($urandom_range(0, 9))
               0:       decl = 0;
               1:       decl = body_buf.size() > 1 ? $urandom_range(1, body_buf.size() - 1) :
                                                     body_buf.size();
               2:       decl = body_buf.size() + $urandom_range(1, 30);
               3:       decl = $urandom_range(0, 16'hFFFF);
               default: decl = body_buf.size();
            endcase
            if (decl == 0)
               body_buf.delete();
            hdr_at.insert(hdr_at.size(), read_buf.size());
            put_header(mid, decl[15:0]);
            foreach (body_buf[i])
               add_read_byte(body_buf[i]);
            msgs++;
         end
         // broken sync somewhere in one header
         if ($urandom_range(0, 9) == 0) begin
            k = hdr_at[$urandom_range(0, hdr_at.size() - 1)] + $urandom_range(0, SYNC_LEN - 1);
            read_buf[k] = read_buf[k] ^ (8'h01 << $urandom_range(0, 7));
         end
         // read may end in the middle of something
         if ($urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, read_buf.size());
            while (read_buf.size() > n)
               void'(read_buf.pop_back());
         end
      end
      used = read_buf.size() < READ_LIMIT ? read_buf.size() : READ_LIMIT;
      push_read(drain);
   endtask

   task automatic fill_random(input int unsigned target, input bit with_pause,
                              input bit with_long);
      int unsigned counted, used;
      bit paused;
      counted = 0;
      paused = 1'b0;
      while (counted < target) begin
         queue_read(with_pause && !paused && counted >= target / 2,
                    with_long && counted == 0, used);
         if (with_pause && counted >= target / 2)
            paused = 1'b1;
         counted += used;
      end
   endtask

   task automatic wait_idle();
      do
         @(negedge clock);
      while (rx_bytes.size() != 0 || due_results.size() != 0 || req_tvalid);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin : stimulus
      int k;
      logic [15:0] v;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // read too short to hold a header
      add_read_byte(8'hFF);
      push_read(1'b0);
      // one frame ending on the last byte of the read: frame plus status
      put_header(match_id, 16'd3);
      add_read_byte(8'h00);
      add_read_byte(8'hFF);
      add_read_byte(8'hFF);
      push_read(1'b0);
      // first header fails sync
      repeat (HDR_LEN) add_read_byte(8'h00);
      push_read(1'b0);
      fill_random(200, 1'b0, 1'b0);

      for (k = 0; k < 4; k++) begin
         wait_idle();
         v = (k == 0) ? 16'h0000 : (k == 1) ? 16'hFFFF : 16'($urandom);
         @(posedge clock);
         csr_wr_en <= 1'b1;
         csr_wr_data <= v;
         @(posedge clock);
         csr_wr_en <= 1'b0;
         match_id = v;
         @(negedge clock);
         if (k == 3)
            calm = 1'b1;
         fill_random(215, k == 1, k == 2);
      end
      wait_idle();

      if (errors == 0)
         $display("can_stream_deframer test passed");
      else
         $display("can_stream_deframer test failed");
      $finish;
   end

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin : drive_proc
      rx_item_type nxt;
      bit sent;
      int unsigned gap_left;
      sent = req_tvalid && req_tready;
      if (sent)
         deframe_byte(req_tdata, req_tlast);
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (sent || !req_tvalid) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (rx_bytes.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (rx_bytes[0].drain_first && due_results.size() != 0) begin
            // hold the next read back until the block has drained
            req_tvalid <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(0, 2);
            req_tvalid <= 1'b0;
         end else begin
            nxt = rx_bytes[0];
            rx_bytes.delete(0);
            req_tdata <= nxt.data;
            req_tlast <= nxt.ends_read;
            req_tvalid <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   always @(posedge clock) begin : ready_proc
      int unsigned hold_left;
      int unsigned stall_left;
      bit long_hold_done;
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!long_hold_done && rx_bytes.size() > 100) begin
         // long back-pressure while the sender keeps offering bytes
         long_hold_done = 1'b1;
         hold_left = LONG_HOLD - 1;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $display("%0d ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : check_proc
      cfd_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_results.size() == 0) begin
            $display("%0d ns: unexpected result, expected none, actual kind %0b tdata %0h",
                     $time, rsp_tuser, rsp_tdata);
            errors++;
         end else begin
            want = due_results[0];
            due_results.delete(0);
            check_field("result_kind", 64'(want.kind), 64'(rsp_tuser));
            check_field("frame_id", 64'(want.id), 64'(rsp_tdata[31:0]));
            check_field("frame_extended", 64'(want.ext), 64'(rsp_tdata[32]));
            check_field("frame_length", 64'(want.len), 64'(rsp_tdata[36:33]));
            check_field("payload", want.data, rsp_tdata[100:37]);
            check_field("read_status", 64'(want.status), 64'(rsp_tdata[102:101]));
            check_field("tdata padding", 64'd0, 64'(rsp_tdata[103]));
            check_field("last_of_run", 64'(want.last), 64'(rsp_tlast));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("can_stream_deframer test failed");
         $finish;
      end
   end

endmodule
